/* src/port_bank_map_and_wait_state_regs_core_assert.svh */
// Assertion macros shared by the memory-control register block.
`ifndef PORT_BANK_MAP_AND_WAIT_STATE_REGS_CORE_ASSERT_SVH
`define PORT_BANK_MAP_AND_WAIT_STATE_REGS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PBMW_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBMW_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pbmw_pkg.sv */
// ----------------------------------------------------------------------------
// pbmw_pkg
// Types, port codes and helper functions for the memory-control register block.
// ----------------------------------------------------------------------------
package pbmw_pkg;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Port addresses (low byte)
  localparam logic [7:0] PORT_BANK_CTRL = 8'h04;
  localparam logic [7:0] PORT_BANK_C    = 8'h05;
  localparam logic [7:0] PORT_BANK_A    = 8'h06;
  localparam logic [7:0] PORT_BANK_B    = 8'h07;
  localparam logic [7:0] PORT_UNLOCK    = 8'h14;
  localparam logic [7:0] PORT_SPEED     = 8'h20;
  localparam logic [7:0] PORT_EXEC_PROT = 8'h21;
  localparam logic [7:0] PORT_PROT_22   = 8'h22;
  localparam logic [7:0] PORT_PROT_23   = 8'h23;
  localparam logic [7:0] PORT_PROT_25   = 8'h25;
  localparam logic [7:0] PORT_PROT_26   = 8'h26;
  localparam logic [7:0] PORT_MISC_27   = 8'h27;
  localparam logic [7:0] PORT_MISC_28   = 8'h28;
  localparam logic [7:0] PORT_LCD_0     = 8'h29;
  localparam logic [7:0] PORT_LCD_1     = 8'h2A;
  localparam logic [7:0] PORT_LCD_2     = 8'h2B;
  localparam logic [7:0] PORT_LCD_3     = 8'h2C;
  localparam logic [7:0] PORT_MISC_2D   = 8'h2D;
  localparam logic [7:0] PORT_MEM_WAIT  = 8'h2E;
  localparam logic [7:0] PORT_MISC_2F   = 8'h2F;

  // Indexes into the 0x20..0x2F byte file
  localparam logic [3:0] MISC_EXEC  = 4'h1;
  localparam logic [3:0] MISC_LCD0  = 4'h9;
  localparam logic [3:0] MISC_LCD1  = 4'hA;
  localparam logic [3:0] MISC_LCD2  = 4'hB;
  localparam logic [3:0] MISC_LCD3  = 4'hC;
  localparam logic [3:0] MISC_2D    = 4'hD;
  localparam logic [3:0] MISC_MEM   = 4'hE;

  localparam logic [7:0] EXEC_PROT_RD_MASK = 8'h33;

  typedef struct packed {
    logic       pdone;
    logic [7:0] wdata;
    logic [7:0] port;
    op_t        op;
  } cmd_t;

  // Post-access view of the state handed to the mapping logic
  typedef struct packed {
    logic [7:0]  bank_ctrl;
    logic [3:0]  bank_c;
    logic [7:0]  bank_a;
    logic [7:0]  bank_b;
    logic [1:0]  speed;
    logic [7:0]  mem_port;
    logic [7:0]  lcd_port;
    logic [15:0] exec_mask;
    logic        unlock;
  } view_t;

  typedef struct packed {
    logic        fast_mode;
    logic        flash_unlocked;
    logic [15:0] no_exec_mask;
    logic [5:0]  lcd_delay;
    logic [5:0]  mem_wait_flags;
    logic [7:0]  bank3_page;
    logic [7:0]  bank2_page;
    logic [7:0]  bank1_page;
    logic [7:0]  read_data;
  } res_t;

  function automatic logic [7:0] page_of(input logic [7:0] sel);
    logic [7:0] pg;
    if (sel[7]) begin
      pg = {5'b10000, sel[2:0]};
    end else begin
      pg = {1'b0, sel[6:0]};
    end
    return pg;
  endfunction

  function automatic logic [15:0] exec_mask_of(input logic [1:0] code);
    logic [15:0] m;
    case (code)
      2'd0:    m = 16'h5555;
      2'd1:    m = 16'h9999;
      2'd2:    m = 16'hF9F9;
      default: m = 16'hFFF9;
    endcase
    return m;
  endfunction

endpackage

/* src/port_bank_map_and_wait_state_regs_core.sv */
// ----------------------------------------------------------------------------
// port_bank_map_and_wait_state_regs_core
// Memory-control port registers: bank mapping, wait states, flash unlock.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one port access per word. in_tuser = op (0 read, 1 write);
//           in_tdata = port, write byte, protect_done.
//   out_* : one result word per access, in order: read byte (0 on a write)
//           and the bank pages, wait flags, LCD delay, no-exec mask, unlock
//           and fast flags as they stand after the access.
//   Path: an accepted word passes the input register, then the result
//   register, before it shows on out_*.
//   Throughput: one word per cycle while out_tready is high; the decode and
//   mapping logic between the two registers is a single pass.
//   Stalls: with out_tready low the result register holds and the input
//   register still takes one more word; in_tready drops only when both are
//   full. Register state updates when a word moves into the result register.
//   Reset (rst_n low, synchronous): both stages empty, all port registers,
//   the unlock flag and the no-exec mask cleared to zero.
// ----------------------------------------------------------------------------
`include "port_bank_map_and_wait_state_regs_core_assert.svh"

module port_bank_map_and_wait_state_regs_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] port, [15:8] write_data, [16] protect_done, [23:17] zero
  input  logic [pbmw_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] op
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] read_data, [15:8] bank1_page, [23:16] bank2_page, [31:24] bank3_page,
  // [37:32] mem_wait_flags, [43:38] lcd_delay, [59:44] no_exec_mask,
  // [60] flash_unlocked, [61] fast_mode, [63:62] zero
  output logic [pbmw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pbmw_pkg::*;

  logic   in_v_r;
  cmd_t   cmd_r;
  logic   out_v_r;
  res_t   res_r;
  logic   adv;
  logic   fire;
  view_t  view;
  logic [7:0] rd_data;
  res_t   res_nxt;

  assign adv       = !out_v_r || out_tready;
  assign fire      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  pbmw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fire),
    .cmd     (cmd_r),
    .view    (view),
    .rd_data (rd_data)
  );

  pbmw_map u_map (
    .view    (view),
    .rd_data (rd_data),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (adv) out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r.op    <= op_t'(in_tuser[0]);
      cmd_r.port  <= in_tdata[7:0];
      cmd_r.wdata <= in_tdata[15:8];
      cmd_r.pdone <= in_tdata[16];
    end
    if (fire) res_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r};

  `PBMW_ASSERT_NXT(a_fire_gives_result, clk, rst_n, fire, out_v_r,
    "accepted word did not reach the result register")
  `PBMW_ASSERT_NXT(a_stage_holds, clk, rst_n,
    in_v_r && out_v_r && !out_tready, in_v_r && $stable(cmd_r),
    "input stage lost or changed its word during a stall")
  `PBMW_ASSERT_IMP(a_result_from_fire, clk, rst_n, $rose(out_v_r), $past(fire),
    "result appeared without a word moving through")

endmodule

/* src/pbmw_regs.sv */
// ----------------------------------------------------------------------------
// pbmw_regs
// Port register file: write decode with protection, read mux, post-access view.
// ----------------------------------------------------------------------------
`include "port_bank_map_and_wait_state_regs_core_assert.svh"

module pbmw_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  pbmw_pkg::cmd_t  cmd,
  output pbmw_pkg::view_t view,
  output logic [7:0]      rd_data
);
  import pbmw_pkg::*;

  logic [7:0]  bank_ctrl_r, bank_ctrl_nxt;
  logic [3:0]  bank_c_r, bank_c_nxt;
  logic [7:0]  bank_a_r, bank_a_nxt;
  logic [7:0]  bank_b_r, bank_b_nxt;
  logic [7:0]  speed_r, speed_nxt;
  logic [7:0]  misc_r [16];
  logic [7:0]  misc_nxt [16];
  logic        unlock_r, unlock_nxt;
  logic [15:0] epm_r, epm_nxt;
  logic        is_wr;
  logic        priv;

  assign is_wr = wr_en && (cmd.op == OP_WRITE);
  assign priv  = unlock_r && cmd.pdone;

  always_comb begin
    bank_ctrl_nxt = bank_ctrl_r;
    bank_c_nxt    = bank_c_r;
    bank_a_nxt    = bank_a_r;
    bank_b_nxt    = bank_b_r;
    speed_nxt     = speed_r;
    misc_nxt      = misc_r;
    unlock_nxt    = unlock_r;
    epm_nxt       = epm_r;
    if (is_wr) begin
      case (cmd.port)
        PORT_BANK_CTRL: bank_ctrl_nxt = cmd.wdata;
        PORT_BANK_C:    bank_c_nxt    = cmd.wdata[3:0];
        PORT_BANK_A:    bank_a_nxt    = cmd.wdata;
        PORT_BANK_B:    bank_b_nxt    = cmd.wdata;
        PORT_UNLOCK: begin
          if (cmd.pdone) unlock_nxt = cmd.wdata[0];
        end
        PORT_SPEED:     speed_nxt     = cmd.wdata;
        PORT_EXEC_PROT: begin
          if (priv) begin
            misc_nxt[MISC_EXEC] = cmd.wdata;
            epm_nxt             = exec_mask_of(cmd.wdata[5:4]);
          end
        end
        PORT_PROT_22, PORT_PROT_23, PORT_PROT_25, PORT_PROT_26: begin
          if (priv) misc_nxt[cmd.port[3:0]] = cmd.wdata;
        end
        PORT_MISC_27, PORT_MISC_28, PORT_LCD_0, PORT_LCD_1, PORT_LCD_2,
        PORT_LCD_3, PORT_MISC_2D, PORT_MEM_WAIT, PORT_MISC_2F: begin
          misc_nxt[cmd.port[3:0]] = cmd.wdata;
        end
        default: ;
      endcase
    end
  end

  // Reads see the state before the access; reads never change it
  always_comb begin
    case (cmd.port)
      PORT_BANK_C:    rd_data = {4'b0000, bank_c_r};
      PORT_BANK_A:    rd_data = bank_a_r;
      PORT_BANK_B:    rd_data = bank_b_r;
      PORT_SPEED:     rd_data = {6'b000000, speed_r[1:0]};
      PORT_EXEC_PROT: rd_data = misc_r[MISC_EXEC] & EXEC_PROT_RD_MASK;
      PORT_MISC_2D:   rd_data = {6'b000000, misc_r[MISC_2D][1:0]};
      PORT_PROT_22, PORT_PROT_23, PORT_PROT_25, PORT_PROT_26, PORT_MISC_27,
      PORT_MISC_28, PORT_LCD_0, PORT_LCD_1, PORT_LCD_2, PORT_LCD_3,
      PORT_MEM_WAIT, PORT_MISC_2F: rd_data = misc_r[cmd.port[3:0]];
      default:        rd_data = 8'h00;
    endcase
    if (cmd.op == OP_WRITE) rd_data = 8'h00;
  end

  // LCD port picked by the speed setting after the access
  always_comb begin
    view.bank_ctrl = bank_ctrl_nxt;
    view.bank_c    = bank_c_nxt;
    view.bank_a    = bank_a_nxt;
    view.bank_b    = bank_b_nxt;
    view.speed     = speed_nxt[1:0];
    view.mem_port  = misc_nxt[MISC_MEM];
    view.exec_mask = epm_nxt;
    view.unlock    = unlock_nxt;
    case (speed_nxt[1:0])
      2'd0:    view.lcd_port = misc_nxt[MISC_LCD0];
      2'd1:    view.lcd_port = misc_nxt[MISC_LCD1];
      2'd2:    view.lcd_port = misc_nxt[MISC_LCD2];
      default: view.lcd_port = misc_nxt[MISC_LCD3];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_ctrl_r <= 8'h00;
      bank_c_r    <= 4'h0;
      bank_a_r    <= 8'h00;
      bank_b_r    <= 8'h00;
      speed_r     <= 8'h00;
      unlock_r    <= 1'b0;
      epm_r       <= 16'h0000;
      for (int i = 0; i < 16; i++) begin
        misc_r[i] <= 8'h00;
      end
    end else begin
      bank_ctrl_r <= bank_ctrl_nxt;
      bank_c_r    <= bank_c_nxt;
      bank_a_r    <= bank_a_nxt;
      bank_b_r    <= bank_b_nxt;
      speed_r     <= speed_nxt;
      unlock_r    <= unlock_nxt;
      epm_r       <= epm_nxt;
      misc_r      <= misc_nxt;
    end
  end

  `PBMW_ASSERT_NXT(a_unlock_hold, clk, rst_n,
    !(is_wr && cmd.port == PORT_UNLOCK && cmd.pdone), $stable(unlock_r),
    "unlock flag changed without a completed unlock write")
  `PBMW_ASSERT_NXT(a_epm_hold, clk, rst_n,
    !(is_wr && cmd.port == PORT_EXEC_PROT && priv), $stable(epm_r),
    "no-execute mask changed without a privileged write")
  `PBMW_ASSERT_NXT(a_read_no_side, clk, rst_n, !is_wr,
    $stable(bank_a_r) && $stable(bank_b_r) && $stable(speed_r) && $stable(bank_ctrl_r),
    "state changed on a cycle without a write")

endmodule

/* src/pbmw_map.sv */
// ----------------------------------------------------------------------------
// pbmw_map
// Bank page mapping, wait-state flags and LCD delay from the register view.
// ----------------------------------------------------------------------------
module pbmw_map (
  input  pbmw_pkg::view_t view,
  input  logic [7:0]      rd_data,
  output pbmw_pkg::res_t  res
);
  import pbmw_pkg::*;

  logic [7:0] pa, pb, pc;
  logic [2:0] flash_w, ram_w;

  assign pa = page_of(view.bank_a);
  assign pb = page_of(view.bank_b);
  assign pc = {5'b10000, view.bank_c[2:0]};

  // LCD port bits 0/1 enable the flash/RAM halves of port 0x2E
  assign flash_w = view.lcd_port[0] ? view.mem_port[2:0] : 3'b000;
  assign ram_w   = view.lcd_port[1] ? view.mem_port[6:4] : 3'b000;

  always_comb begin
    res.read_data = rd_data;
    if (view.bank_ctrl[0]) begin
      // two-page mode: bank A spans banks 1 and 2
      res.bank1_page = {pa[7:1], 1'b0};
      res.bank2_page = {pa[7:1], 1'b1};
      res.bank3_page = pb;
    end else begin
      res.bank1_page = pa;
      res.bank2_page = pb;
      res.bank3_page = pc;
    end
    res.mem_wait_flags = {ram_w, flash_w};
    res.lcd_delay      = view.lcd_port[7:2];
    res.no_exec_mask   = view.exec_mask;
    res.flash_unlocked = view.unlock;
    res.fast_mode      = |view.speed;
  end

endmodule
